@@ rtl/core/time_slot_event_queue_core_assert.svh @@
// ----------------------------------------------------------------------------
// Time slot event queue assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TIME_SLOT_EVENT_QUEUE_CORE_ASSERT_SVH
`define TIME_SLOT_EVENT_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define TSEQ_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tseq assertion failed");

`define TSEQ_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tseq assertion failed");

`else

`define TSEQ_ASSERT_IMP(lbl, clk, rst, a, b)
`define TSEQ_ASSERT_NXT(lbl, clk, rst, a, b)

`endif

`endif

@@ rtl/core/tseq_pkg.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue package
// Event codes, controller types and time decode helpers.
// ----------------------------------------------------------------------------
package tseq_pkg;

  localparam int CODE_W = 3;
  localparam int TIME_W = 8;

  localparam logic [TIME_W-1:0] SEC_TEMP  = 8'd7;
  localparam logic [TIME_W-1:0] SEC_OTHER = 8'd30;
  localparam logic [TIME_W-1:0] SEC_WIFI  = 8'd58;
  localparam logic [TIME_W-1:0] SEC_ZERO  = 8'd0;
  localparam int SLOT_LEN = 28;
  localparam logic [4:0] SLOT_LAST  = 5'd27;
  localparam logic [4:0] SLOT_FIRST = 5'd0;
  localparam logic [4:0] SLOT_NEXT  = 5'd1;

  typedef enum logic [CODE_W-1:0] {
    EV_TEMP         = 3'd0,
    EV_OTHER        = 3'd1,
    EV_WIFIWEB      = 3'd2,
    EV_WIFIGETTEMP  = 3'd3,
    EV_WIFIGETOTHER = 3'd4
  } ev_code_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic sample;
    logic pop_empty;
    logic pop_start;
    logic load_read;
  } cmd_t;

  typedef struct packed {
    logic empty;
  } stat_t;

  typedef struct packed {
    logic     hit;
    ev_code_t code;
  } ev_t;

  function automatic logic [TIME_W-1:0] bcd_decode(input logic [7:0] b);
    logic [TIME_W-1:0] hi;
    hi = TIME_W'(b[7:4]);
    return (hi << 3) + (hi << 1) + TIME_W'(b[3:0]);
  endfunction

  // value is at most 165, so one subtract of up to five slot lengths covers it
  function automatic logic [4:0] slot_of(input logic [TIME_W-1:0] m);
    logic [TIME_W-1:0] r;
    r = m;
    if (r >= TIME_W'(SLOT_LEN * 5)) r = r - TIME_W'(SLOT_LEN * 5);
    else if (r >= TIME_W'(SLOT_LEN * 4)) r = r - TIME_W'(SLOT_LEN * 4);
    else if (r >= TIME_W'(SLOT_LEN * 3)) r = r - TIME_W'(SLOT_LEN * 3);
    else if (r >= TIME_W'(SLOT_LEN * 2)) r = r - TIME_W'(SLOT_LEN * 2);
    else if (r >= TIME_W'(SLOT_LEN)) r = r - TIME_W'(SLOT_LEN);
    return r[4:0];
  endfunction

  function automatic ev_t classify(input logic [TIME_W-1:0] s,
                                   input logic [TIME_W-1:0] m,
                                   input logic wireless);
    ev_t e;
    logic [4:0] slot;
    slot = slot_of(m);
    e.hit = 1'b1;
    e.code = EV_TEMP;
    if (s == SEC_TEMP) e.code = EV_TEMP;
    else if (s == SEC_OTHER) e.code = EV_OTHER;
    else if (wireless && slot == SLOT_LAST && s == SEC_WIFI) e.code = EV_WIFIWEB;
    else if (wireless && slot == SLOT_FIRST && s == SEC_ZERO) e.code = EV_WIFIGETTEMP;
    else if (wireless && slot == SLOT_FIRST && s == SEC_WIFI) e.code = EV_WIFIWEB;
    else if (wireless && slot == SLOT_NEXT && s == SEC_ZERO) e.code = EV_WIFIGETOTHER;
    else e.hit = 1'b0;
    return e;
  endfunction

endpackage

@@ rtl/core/tseq_if.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tseq_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] sec_bcd;
  logic [7:0] min_bcd;
  logic [7:0] hour_bcd;

  modport source (output valid, req_type, sec_bcd, min_bcd, hour_bcd, input ready);
  modport sink   (input valid, req_type, sec_bcd, min_bcd, hour_bcd, output ready);
endinterface

interface tseq_rsp_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [2:0] event_code;
  logic       pending;
  logic       dropped;
  logic [7:0] seconds;
  logic [7:0] minutes;
  logic [7:0] hours;

  modport source (output valid, event_valid, event_code, pending, dropped,
                  seconds, minutes, hours, input ready);
  modport sink   (input valid, event_valid, event_code, pending, dropped,
                  seconds, minutes, hours, output ready);
endinterface

@@ rtl/core/time_slot_event_queue_core.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue core
// Decodes BCD clock samples into slot events and queues them for popping.
//
//   channel  dir  request
//   req      in   req_type, sec_bcd, min_bcd, hour_bcd
//   rsp      out  event_valid, event_code, pending, dropped, seconds, ...
//   cfg      in   cfg_we, cfg_wdata (wireless_ready)
//
// A sample or an empty pop loads the result register directly; a non-empty pop
// goes through ST_READ for the registered read of the event store first.
// Reset is synchronous; the event store is not cleared.
// A request is taken in ST_IDLE when the result register is free or being emptied.
// ----------------------------------------------------------------------------
`include "time_slot_event_queue_core_assert.svh"

module time_slot_event_queue_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  tseq_req_if.sink          req,
  tseq_rsp_if.source        rsp
);

  tseq_pkg::cmd_t  cmd;
  tseq_pkg::stat_t stat;

  tseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_pop    (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tseq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .sec_bcd     (req.sec_bcd),
    .min_bcd     (req.min_bcd),
    .hour_bcd    (req.hour_bcd),
    .cmd         (cmd),
    .stat        (stat),
    .event_valid (rsp.event_valid),
    .event_code  (rsp.event_code),
    .pending     (rsp.pending),
    .dropped     (rsp.dropped),
    .seconds     (rsp.seconds),
    .minutes     (rsp.minutes),
    .hours       (rsp.hours)
  );

  `TSEQ_ASSERT_NXT(a_read_blocks, clk, rst, cmd.pop_start, !req.ready)
  `TSEQ_ASSERT_IMP(a_drop_pending, clk, rst, rsp.valid && rsp.dropped, rsp.pending)
  `TSEQ_ASSERT_IMP(a_code_range, clk, rst, rsp.valid && rsp.event_valid,
                   rsp.event_code <= tseq_pkg::EV_WIFIGETOTHER)

endmodule

@@ rtl/core/tseq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tseq_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tseq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue controller
// Request acceptance, pop read sequencing and result valid.
// ----------------------------------------------------------------------------
module tseq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_pop,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tseq_pkg::stat_t stat,
  output tseq_pkg::cmd_t  cmd
);

  tseq_pkg::state_t state, state_next;
  logic out_valid_next;
  logic out_free;
  logic acc;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    acc = 1'b0;
    case (state)
      tseq_pkg::ST_IDLE: begin
        in_ready = out_free;
        acc = in_valid && out_free;
        cmd.sample    = acc && !in_pop;
        cmd.pop_empty = acc && in_pop && stat.empty;
        cmd.pop_start = acc && in_pop && !stat.empty;
      end
      tseq_pkg::ST_READ: begin
        cmd.load_read = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tseq_pkg::ST_IDLE: if (cmd.pop_start) state_next = tseq_pkg::ST_READ;
      tseq_pkg::ST_READ: if (out_free) state_next = tseq_pkg::ST_IDLE;
      default: state_next = tseq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (cmd.sample || cmd.pop_empty || cmd.load_read) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tseq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/tseq_dp.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue datapath
// Time decode, event rules, ring pointers, event store and result register.
// ----------------------------------------------------------------------------
module tseq_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic [7:0]      sec_bcd,
  input  logic [7:0]      min_bcd,
  input  logic [7:0]      hour_bcd,
  input  tseq_pkg::cmd_t  cmd,
  output tseq_pkg::stat_t stat,
  output logic            event_valid,
  output logic [2:0]      event_code,
  output logic            pending,
  output logic            dropped,
  output logic [7:0]      seconds,
  output logic [7:0]      minutes,
  output logic [7:0]      hours
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic wireless_ready;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic [tseq_pkg::TIME_W-1:0] s_dec, m_dec, h_dec;
  tseq_pkg::ev_t ev;
  logic full, push;
  logic [tseq_pkg::CODE_W-1:0] rd_data;

  assign wr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
  assign rd_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);

  assign s_dec = tseq_pkg::bcd_decode(sec_bcd);
  assign m_dec = tseq_pkg::bcd_decode(min_bcd);
  assign h_dec = tseq_pkg::bcd_decode(hour_bcd);
  assign ev    = tseq_pkg::classify(s_dec, m_dec, wireless_ready);

  assign full       = (wr_inc == rd_ptr);
  assign push       = cmd.sample && ev.hit && !full;
  assign stat.empty = (wr_ptr == rd_ptr);

  tseq_ram #(
    .WIDTH (tseq_pkg::CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push),
    .waddr (wr_inc),
    .wdata (ev.code),
    .re    (cmd.pop_start),
    .raddr (rd_inc),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wireless_ready <= 1'b0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      seconds <= '0;
      minutes <= '0;
      hours   <= '0;
    end else begin
      if (cfg_we) wireless_ready <= cfg_wdata;
      if (push) wr_ptr <= wr_inc;
      if (cmd.pop_start) rd_ptr <= rd_inc;
      if (cmd.sample) begin
        seconds <= s_dec;
        minutes <= m_dec;
        hours   <= h_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      event_valid <= 1'b0;
      event_code  <= tseq_pkg::EV_TEMP;
      pending     <= ev.hit || !stat.empty;
      dropped     <= ev.hit && full;
    end else if (cmd.pop_empty) begin
      event_valid <= 1'b0;
      event_code  <= tseq_pkg::EV_TEMP;
      pending     <= 1'b0;
      dropped     <= 1'b0;
    end else if (cmd.load_read) begin
      event_valid <= 1'b1;
      event_code  <= rd_data;
      pending     <= !stat.empty;
      dropped     <= 1'b0;
    end
  end

endmodule

@@ dv/time_slot_event_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// Time slot event queue core testbench
// Sends sample and pop requests in random bursts and gaps while the result
// side stalls on its own pattern. Every result is checked field by field
// against an untimed model of the decoder and the ring queue.
// ----------------------------------------------------------------------------
module time_slot_event_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [5:0] PHASE_WL = 6'b110101;

  typedef struct {
    logic       is_pop;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
  } tsq_req_t;

  typedef struct {
    logic       event_valid;
    logic [2:0] event_code;
    logic       pending;
    logic       dropped;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
  } tsq_rsp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  tseq_req_if req ();
  tseq_rsp_if rsp ();

  time_slot_event_queue_core #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  // model state
  logic                wl_ready;
  int                  wr_ptr;
  int                  rd_ptr;
  tseq_pkg::ev_code_t  slot_store [DEPTH];
  logic [7:0]          last_s;
  logic [7:0]          last_m;
  logic [7:0]          last_h;

  tsq_req_t   pending_requests [$];
  tsq_rsp_t   expected_results [$];
  int         err_cnt;
  int         hold_orders;
  int         hold_served;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] bcd_value(logic [7:0] b);
    return {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
  endfunction

  function automatic tseq_pkg::ev_t slot_event(logic [7:0] s, logic [7:0] m);
    tseq_pkg::ev_t e;
    int            slot;
    slot = m % tseq_pkg::SLOT_LEN;
    e.hit = 1'b1;
    e.code = tseq_pkg::EV_TEMP;
    if (s == tseq_pkg::SEC_TEMP) e.code = tseq_pkg::EV_TEMP;
    else if (s == tseq_pkg::SEC_OTHER) e.code = tseq_pkg::EV_OTHER;
    else if (wl_ready && slot == tseq_pkg::SLOT_LAST && s == tseq_pkg::SEC_WIFI)
      e.code = tseq_pkg::EV_WIFIWEB;
    else if (wl_ready && slot == tseq_pkg::SLOT_FIRST && s == tseq_pkg::SEC_ZERO)
      e.code = tseq_pkg::EV_WIFIGETTEMP;
    else if (wl_ready && slot == tseq_pkg::SLOT_FIRST && s == tseq_pkg::SEC_WIFI)
      e.code = tseq_pkg::EV_WIFIWEB;
    else if (wl_ready && slot == tseq_pkg::SLOT_NEXT && s == tseq_pkg::SEC_ZERO)
      e.code = tseq_pkg::EV_WIFIGETOTHER;
    else e.hit = 1'b0;
    return e;
  endfunction

  function automatic tsq_rsp_t queue_model_step(tsq_req_t r);
    tsq_rsp_t      o;
    tseq_pkg::ev_t e;
    int            nxt;
    o = '{default: '0};
    if (!r.is_pop) begin
      last_s = bcd_value(r.sec);
      last_m = bcd_value(r.min);
      last_h = bcd_value(r.hour);
      e = slot_event(last_s, last_m);
      if (e.hit) begin
        nxt = (wr_ptr + 1) % DEPTH;
        if (nxt != rd_ptr) begin
          wr_ptr = nxt;
          slot_store[nxt] = e.code;
        end else begin
          o.dropped = 1'b1;
        end
      end
    end else if (wr_ptr != rd_ptr) begin
      rd_ptr = (rd_ptr + 1) % DEPTH;
      o.event_valid = 1'b1;
      o.event_code = slot_store[rd_ptr];
    end
    o.pending = (wr_ptr != rd_ptr);
    o.seconds = last_s;
    o.minutes = last_m;
    o.hours = last_h;
    return o;
  endfunction

  // any nibble pair that decodes to v, canonical BCD at least half the time for v below 100
  function automatic logic [7:0] bcd_encode(int v);
    int hmin;
    int hmax;
    int hi;
    hmax = (v / 10 > 15) ? 15 : v / 10;
    hmin = (v > 15) ? (v - 6) / 10 : 0;
    if ($urandom_range(1, 0) == 1 && v < 100) hi = v / 10;
    else hi = $urandom_range(hmax, hmin);
    return 8'((hi << 4) | (v - 10 * hi));
  endfunction

  function automatic tsq_req_t mk_pop();
    tsq_req_t r;
    r.is_pop = 1'b1;
    r.sec = 8'($urandom);
    r.min = 8'($urandom);
    r.hour = 8'($urandom);
    return r;
  endfunction

  function automatic tsq_req_t mk_raw();
    tsq_req_t r;
    r = mk_pop();
    r.is_pop = 1'b0;
    return r;
  endfunction

  function automatic tsq_req_t mk_slot_hit();
    tsq_req_t r;
    int       s;
    int       slot;
    int       k;
    case ($urandom_range(9, 0))
      0, 1: s = tseq_pkg::SEC_ZERO;
      2, 3: s = tseq_pkg::SEC_TEMP;
      4, 5: s = tseq_pkg::SEC_OTHER;
      6, 7: s = tseq_pkg::SEC_WIFI;
      8: begin
        case ($urandom_range(5, 0))
          0: s = 6;
          1: s = 8;
          2: s = 29;
          3: s = 31;
          4: s = 57;
          default: s = 59;
        endcase
      end
      default: s = $urandom_range(165, 0);
    endcase
    case ($urandom_range(4, 0))
      0: slot = tseq_pkg::SLOT_LAST;
      1: slot = tseq_pkg::SLOT_FIRST;
      2: slot = tseq_pkg::SLOT_NEXT;
      default: slot = $urandom_range(27, 0);
    endcase
    k = $urandom_range((165 - slot) / tseq_pkg::SLOT_LEN, 0);
    r.is_pop = 1'b0;
    r.sec = bcd_encode(s);
    r.min = bcd_encode(tseq_pkg::SLOT_LEN * k + slot);
    r.hour = 8'($urandom);
    return r;
  endfunction

  // runs that fill the queue, drain it, or mix both
  task automatic queue_random(int n);
    int mode;
    int run;
    int pick;
    while (n > 0) begin
      mode = $urandom_range(2, 0);
      run = $urandom_range(40, 5);
      for (int i = 0; i < run && n > 0; i++) begin
        pick = $urandom_range(99, 0);
        case (mode)
          0: begin
            if (pick < 85) pending_requests.push_back(mk_slot_hit());
            else if (pick < 95) pending_requests.push_back(mk_pop());
            else pending_requests.push_back(mk_raw());
          end
          1: begin
            if (pick < 75) pending_requests.push_back(mk_pop());
            else if (pick < 95) pending_requests.push_back(mk_slot_hit());
            else pending_requests.push_back(mk_raw());
          end
          default: begin
            if (pick < 40) pending_requests.push_back(mk_slot_hit());
            else if (pick < 75) pending_requests.push_back(mk_pop());
            else pending_requests.push_back(mk_raw());
          end
        endcase
        n--;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wireless(logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    wl_ready = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // request driver
  tsq_req_t cur_req;
  int       burst_left;
  int       gap_left;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.req_type <= 1'b0;
      req.sec_bcd <= 8'd0;
      req.min_bcd <= 8'd0;
      req.hour_bcd <= 8'd0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (req.valid && req.ready) expected_results.push_back(queue_model_step(cur_req));
      if (!req.valid || req.ready) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req.valid <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          req.valid <= 1'b1;
          req.req_type <= cur_req.is_pop;
          req.sec_bcd <= cur_req.sec;
          req.min_bcd <= cur_req.min;
          req.hour_bcd <= cur_req.hour;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(16, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end
        end
      end
    end
  end

  // result side stall pattern, with a long hold when ordered
  int hold_left;
  int ready_mode;
  int mode_left;
  int ready_tick;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
      hold_served = 0;
      mode_left = 0;
      ready_mode = 0;
      ready_tick = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (hold_served != hold_orders) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(3, 0);
        mode_left = $urandom_range(80, 20);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= (ready_tick % 3 != 0);
        2: rsp.ready <= ($urandom_range(9, 0) < 7);
        default: rsp.ready <= ($urandom_range(9, 0) < 2);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    tsq_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_valid", 8'(want.event_valid), 8'(rsp.event_valid));
        check_field("event_code", 8'(want.event_code), 8'(rsp.event_code));
        check_field("pending", 8'(want.pending), 8'(rsp.pending));
        check_field("dropped", 8'(want.dropped), 8'(rsp.dropped));
        check_field("seconds", want.seconds, rsp.seconds);
        check_field("minutes", want.minutes, rsp.minutes);
        check_field("hours", want.hours, rsp.hours);
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.sec_bcd = 8'd0;
    req.min_bcd = 8'd0;
    req.hour_bcd = 8'd0;
    rsp.ready = 1'b0;
    wl_ready = 1'b0;
    wr_ptr = 0;
    rd_ptr = 0;
    last_s = 8'd0;
    last_m = 8'd0;
    last_h = 8'd0;
    err_cnt = 0;
    hold_orders = 0;
    foreach (slot_store[i]) slot_store[i] = tseq_pkg::EV_TEMP;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wireless rules off: empty pop, max bytes, plain events, non-BCD decode
    pending_requests.push_back('{1'b1, 8'hFF, 8'hFF, 8'hFF});
    pending_requests.push_back('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    pending_requests.push_back('{1'b0, 8'h07, 8'h00, 8'h00});
    pending_requests.push_back('{1'b0, 8'h2A, 8'h59, 8'h23});
    pending_requests.push_back('{1'b0, 8'h58, 8'h27, 8'h12});
    pending_requests.push_back('{1'b1, 8'h00, 8'h00, 8'h00});
    pending_requests.push_back('{1'b1, 8'h00, 8'h00, 8'h00});
    pending_requests.push_back('{1'b1, 8'h00, 8'h00, 8'h00});
    wait_drained();

    // wireless slots, rule priority, then fill to full and drain past empty
    write_wireless(1'b1);
    pending_requests.push_back('{1'b0, 8'h58, 8'h27, 8'h01});
    pending_requests.push_back('{1'b0, 8'h00, 8'h00, 8'h02});
    pending_requests.push_back('{1'b0, 8'h58, 8'h1A, 8'h03});
    pending_requests.push_back('{1'b0, 8'h00, 8'h01, 8'h04});
    pending_requests.push_back('{1'b0, 8'h07, 8'h00, 8'h05});
    pending_requests.push_back('{1'b0, 8'h30, 8'h27, 8'h06});
    pending_requests.push_back('{1'b0, 8'h00, 8'h29, 8'h07});
    pending_requests.push_back('{1'b0, 8'h07, 8'h56, 8'h08});
    repeat (8) pending_requests.push_back('{1'b1, 8'h00, 8'h00, 8'h00});
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_wireless(PHASE_WL[p]);
      if (p == 1) hold_orders++;
      queue_random(155);
      wait_drained();
    end

    if (err_cnt == 0) $display("time_slot_event_queue_core_tb OK");
    else $display("time_slot_event_queue_core_tb NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("time_slot_event_queue_core_tb NOT OK");
    $finish;
  end

endmodule
